// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared constants, codes and the table entry type.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W      = 65;
    localparam int PADDR_W      = 3;

    localparam logic [31:0] INIT_RESET = 32'd1048576;
    localparam logic [31:0] MAXH_RESET = 32'd16777216;
    localparam logic [31:0] HDR32      = 32'(HEADER_BYTES);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_INIT   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_GROWN     = 3'd1;
    localparam logic [2:0] ST_AT_LIMIT  = 3'd2;
    localparam logic [2:0] ST_DOUBLE    = 3'd3;
    localparam logic [2:0] ST_NULL      = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [PADDR_W-1:0] REG_INIT = 3'd0;
    localparam logic [PADDR_W-1:0] REG_MAXH = 3'd4;

    typedef struct packed {
        logic        free;
        logic [31:0] start;
        logic [31:0] size;
    } entry_t;

endpackage
`default_nettype wire

// ===== hdl/ffa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/ffa_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style port holding the initial and maximum heap sizes.
// ----------------------------------------------------------------------------
module ffa_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ffa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    output      logic [31:0]                 init_bytes,
    output      logic [31:0]                 max_bytes
);
    import ffa_pkg::*;

    logic [31:0] init_reg;
    logic [31:0] maxh_reg;
    logic        wr;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= INIT_RESET;
            maxh_reg <= MAXH_RESET;
        end
        else if (wr)
        begin
            if (paddr == REG_INIT)
            begin
                init_reg <= pwdata;
            end
            else if (paddr == REG_MAXH)
            begin
                maxh_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_INIT: prdata = init_reg;
            REG_MAXH: prdata = maxh_reg;
            default:  prdata = 32'd0;
        endcase
    end

    assign init_bytes = init_reg;
    assign max_bytes  = maxh_reg;
endmodule
`default_nettype wire

// ===== hdl/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block allocator core
// Address-ordered block table in one RAM, scanned and shifted by a sequencer.
// ----------------------------------------------------------------------------
// Init writes entry 0 directly; alloc reads and checks each scanned entry and,
// on a split, shifts the entries above it up; free likewise, plus up to two
// removals, each shifting the entries above it down, all through the single
// RAM read port. One item at a time; the result register frees the input once taken.
// Reset leaves a single free block spanning the reset initial heap size.
module first_fit_block_allocator_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic [31:0]                 request_size,
    input  wire logic [31:0]                 address,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic [2:0]                  status,
    output      logic [31:0]                 result_address,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ffa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready
);
    import ffa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_SHRD  = 9'b000001000,
        S_SHWR  = 9'b000010000,
        S_FIN   = 9'b000100000,
        S_NRD   = 9'b001000000,
        S_NCHK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    // Shift modes: insert moves entries up, remove moves them down.
    state_t          state_reg, state_next;
    logic [1:0]      op_reg;
    logic [31:0]     req_reg, addr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]     ext_reg, ext_next;
    logic            rst_tbl_reg;
    logic            rd_zero_reg;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic            ins_reg, ins_next;
    entry_t          hold_reg, hold_next;   // entry written at the shift end
    logic [CNT_W-1:0] hpos_reg, hpos_next;
    entry_t          cur_reg, cur_next;     // found entry during free
    logic            phase_reg, phase_next; // free: 0 forward, 1 backward
    logic [2:0]      st_reg, st_next;
    logic [31:0]     ra_reg, ra_next;
    logic            ov_reg, ov_next;

    logic [31:0]     init_bytes, max_bytes;
    logic            we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t          wdata, rdata_raw, rd;
    logic [32:0]     grow;

    ffa_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .init_bytes, .max_bytes
    );

    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_tbl (
        .clk, .we, .waddr, .wdata, .raddr, .rdata(rdata_raw)
    );

    // Until the first write of entry 0 after reset, a read of entry 0 returns
    // the reset block. Other entries always come from the RAM.
    always_comb
    begin
        rd = rdata_raw;
        if (rst_tbl_reg && rd_zero_reg)
        begin
            rd.free  = 1'b1;
            rd.start = 32'd0;
            rd.size  = (INIT_RESET > HDR32) ? INIT_RESET - HDR32 : 32'd0;
        end
    end

    assign in_ready       = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign result_address = ra_reg;
    assign grow = {1'b0, ext_reg} + {1'b0, HDR32} + {1'b0, req_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ext_next   = ext_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ins_next   = ins_reg;
        hold_next  = hold_reg;
        hpos_next  = hpos_reg;
        cur_next   = cur_reg;
        phase_next = phase_reg;
        st_next    = st_reg;
        ra_next    = ra_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rd;
        raddr      = i_reg[IDX_W-1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    st_next = ST_OK;
                    ra_next = 32'd0;
                    i_next  = '0;
                    phase_next = 1'b0;
                    if (operation == OP_ALLOC)
                    begin
                        state_next = S_RD;
                    end
                    else if (operation == OP_FREE)
                    begin
                        if (address == 32'd0)
                        begin
                            st_next    = ST_NULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else if (operation == OP_INIT)
                    begin
                        we          = 1'b1;
                        wdata.free  = 1'b1;
                        wdata.start = 32'd0;
                        wdata.size  = (init_bytes > HDR32) ? init_bytes - HDR32 : 32'd0;
                        cnt_next    = CNT_W'(1);
                        ext_next    = init_bytes;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    // Scan ran off the end of the table.
                    if (op_reg == OP_FREE)
                    begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                    else if (ext_reg >= max_bytes || grow[32])
                    begin
                        st_next    = ST_AT_LIMIT;
                        state_next = S_DONE;
                    end
                    else if (cnt_reg >= CNT_W'(MAX_BLOCKS))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = cnt_reg[IDX_W-1:0];
                        wdata.free  = 1'b1;
                        wdata.start = ext_reg;
                        wdata.size  = req_reg;
                        cnt_next    = cnt_reg + CNT_W'(1);
                        ext_next    = grow[31:0];
                        st_next     = ST_GROWN;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (rd.free && rd.size >= req_reg)
                    begin
                        we         = 1'b1;
                        waddr      = i_reg[IDX_W-1:0];
                        wdata.free = 1'b0;
                        ra_next    = rd.start + HDR32;
                        if ((rd.size - req_reg) > HDR32 &&
                            cnt_reg < CNT_W'(MAX_BLOCKS))
                        begin
                            wdata.size     = req_reg;
                            hold_next.free = 1'b1;
                            hold_next.start = rd.start + HDR32 + req_reg;
                            hold_next.size = rd.size - req_reg - HDR32;
                            hpos_next      = i_reg + CNT_W'(1);
                            ins_next       = 1'b1;
                            k_next         = cnt_reg;
                            cnt_next       = cnt_reg + CNT_W'(1);
                            state_next     = S_SHRD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                end
                else if ({1'b0, rd.start} + {1'b0, HDR32} == {1'b0, addr_reg})
                begin
                    if (rd.free)
                    begin
                        st_next    = ST_DOUBLE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next      = rd;
                        cur_next.free = 1'b1;
                        we            = 1'b1;
                        waddr         = i_reg[IDX_W-1:0];
                        wdata.free    = 1'b1;
                        if (i_reg + CNT_W'(1) < cnt_reg)
                        begin
                            raddr      = IDX_W'(i_reg + CNT_W'(1));
                            state_next = S_NCHK;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            state_next = S_NRD;
                        end
                    end
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_NRD:
            begin
                // Backward merge check: read the predecessor.
                if (i_reg != '0)
                begin
                    raddr      = IDX_W'(i_reg - CNT_W'(1));
                    state_next = S_NCHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_NCHK:
            begin
                if (!phase_reg)
                begin
                    if (rd.free)
                    begin
                        cur_next.size = cur_reg.size + HDR32 + rd.size;
                        we          = 1'b1;
                        waddr       = i_reg[IDX_W-1:0];
                        wdata       = cur_reg;
                        wdata.size  = cur_reg.size + HDR32 + rd.size;
                        ins_next    = 1'b0;
                        k_next      = i_reg + CNT_W'(1);
                        hpos_next   = '0;
                        cnt_next    = cnt_reg - CNT_W'(1);
                        state_next  = S_SHRD;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        state_next = S_NRD;
                    end
                end
                else
                begin
                    if (rd.free)
                    begin
                        we         = 1'b1;
                        waddr      = IDX_W'(i_reg - CNT_W'(1));
                        wdata      = rd;
                        wdata.size = rd.size + HDR32 + cur_reg.size;
                        ins_next   = 1'b0;
                        k_next     = i_reg;
                        hpos_next  = CNT_W'(1);
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHRD:
            begin
                // Insert: copy k-1 to k down to hpos. Remove: copy k+1 to k.
                if (ins_reg)
                begin
                    if (k_reg > hpos_reg)
                    begin
                        raddr      = IDX_W'(k_reg - CNT_W'(1));
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    if (k_reg < cnt_reg)
                    begin
                        raddr      = IDX_W'(k_reg + CNT_W'(1));
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SHWR:
            begin
                we     = 1'b1;
                waddr  = k_reg[IDX_W-1:0];
                wdata  = rd;
                k_next = ins_reg ? k_reg - CNT_W'(1) : k_reg + CNT_W'(1);
                state_next = S_SHRD;
            end
            S_FIN:
            begin
                if (ins_reg)
                begin
                    we         = 1'b1;
                    waddr      = hpos_reg[IDX_W-1:0];
                    wdata      = hold_reg;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_FREE && !phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = S_NRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= CNT_W'(1);
            ext_reg     <= INIT_RESET;
            rst_tbl_reg <= 1'b1;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ext_reg   <= ext_next;
            ov_reg    <= ov_next;
            if (we && waddr == '0)
            begin
                rst_tbl_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            req_reg  <= request_size;
            addr_reg <= address;
        end
        rd_zero_reg <= (raddr == '0);
        i_reg     <= i_next;
        k_reg     <= k_next;
        ins_reg   <= ins_next;
        hold_reg  <= hold_next;
        hpos_reg  <= hpos_next;
        cur_reg   <= cur_next;
        phase_reg <= phase_next;
        st_reg    <= st_next;
        ra_reg    <= ra_next;
    end
endmodule
`default_nettype wire

// ===== tb/first_fit_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit block allocator core testbench
// Drives allocate, free and init requests with random gaps and stalls.
// Every response is checked against a behavioral copy of the block table.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core_tb;

    import ffa_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] req;
        logic [31:0] addr;
    } heap_req_t;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] addr;
    } heap_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    first_fit_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .request_size(request_size), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_address(result_address),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the block table.
    logic [31:0] sh_start [MAX_BLOCKS];
    logic [31:0] sh_size  [MAX_BLOCKS];
    logic        sh_free  [MAX_BLOCKS];
    int unsigned sh_count;
    logic [31:0] sh_extent;
    logic [31:0] sh_init_bytes;
    logic [31:0] sh_max_bytes;

    heap_req_t   pending_reqs[$];
    heap_rsp_t   expected_rsps[$];
    logic [31:0] live_offsets[$];
    int unsigned error_count;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned ok_allocs;
    int unsigned merges_seen;
    longint unsigned cycle_count;
    int unsigned send_gap;
    int unsigned recv_gap;
    bit          in_taken;
    bit          out_taken;

    function automatic void heap_setup();
        sh_start[0] = '0;
        sh_size[0]  = (sh_init_bytes > HDR32) ? sh_init_bytes - HDR32 : '0;
        sh_free[0]  = 1'b1;
        sh_count    = 1;
        sh_extent   = sh_init_bytes;
    endfunction

    function automatic void table_insert(int unsigned pos, logic [31:0] s, logic [31:0] z);
        for (int unsigned k = sh_count; k > pos; k--)
        begin
            sh_start[k] = sh_start[k-1];
            sh_size[k]  = sh_size[k-1];
            sh_free[k]  = sh_free[k-1];
        end
        sh_start[pos] = s;
        sh_size[pos]  = z;
        sh_free[pos]  = 1'b1;
        sh_count++;
    endfunction

    function automatic void table_remove(int unsigned pos);
        for (int unsigned k = pos; k + 1 < sh_count; k++)
        begin
            sh_start[k] = sh_start[k+1];
            sh_size[k]  = sh_size[k+1];
            sh_free[k]  = sh_free[k+1];
        end
        sh_count--;
    endfunction

    function automatic heap_rsp_t predict_heap(heap_req_t r);
        heap_rsp_t   p;
        int unsigned i;
        logic [31:0] rem;
        p.st   = ST_OK;
        p.addr = '0;
        if (r.op == OP_ALLOC)
        begin
            for (i = 0; i < sh_count; i++)
            begin
                if (sh_free[i] && sh_size[i] >= r.req)
                begin
                    rem = sh_size[i] - r.req;
                    if (rem > HDR32 && sh_count < MAX_BLOCKS)
                    begin
                        table_insert(i + 1, sh_start[i] + HDR32 + r.req, rem - HDR32);
                        sh_size[i] = r.req;
                    end
                    sh_free[i] = 1'b0;
                    p.addr = sh_start[i] + HDR32;
                    return p;
                end
            end
            if (sh_extent >= sh_max_bytes)
                p.st = ST_AT_LIMIT;
            else if ({32'd0, sh_extent} + 64'(HDR32) + {32'd0, r.req} > 64'hFFFF_FFFF)
                p.st = ST_AT_LIMIT;
            else if (sh_count >= MAX_BLOCKS)
                p.st = ST_FULL;
            else
            begin
                table_insert(sh_count, sh_extent, r.req);
                sh_extent = sh_extent + HDR32 + r.req;
                p.st = ST_GROWN;
            end
        end
        else if (r.op == OP_FREE)
        begin
            if (r.addr == '0)
            begin
                p.st = ST_NULL;
                return p;
            end
            for (i = 0; i < sh_count; i++)
                if ({32'd0, sh_start[i]} + 64'(HDR32) == {32'd0, r.addr})
                    break;
            if (i >= sh_count)
                p.st = ST_UNKNOWN;
            else if (sh_free[i])
                p.st = ST_DOUBLE;
            else
            begin
                sh_free[i] = 1'b1;
                if (i + 1 < sh_count && sh_free[i+1])
                begin
                    sh_size[i] = sh_size[i] + HDR32 + sh_size[i+1];
                    table_remove(i + 1);
                    merges_seen++;
                end
                if (i > 0 && sh_free[i-1])
                begin
                    sh_size[i-1] = sh_size[i-1] + HDR32 + sh_size[i];
                    table_remove(i);
                    merges_seen++;
                end
            end
        end
        else if (r.op == OP_INIT)
            heap_setup();
        return p;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver: one beat at a time from the queue, random gap before each.
    // in_taken marks that the beat on the port was accepted at the last edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 11);
            end
            else if (!in_valid && pending_reqs.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else
                begin
                    heap_req_t r;
                    r = pending_reqs.pop_front();
                    operation    <= r.op;
                    request_size <= r.req;
                    address      <= r.addr;
                    in_valid     <= 1'b1;
                end
            end
        end
    end

    // Sampling the accepted beat at the rising edge; prediction happens here.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            heap_req_t r;
            heap_rsp_t p;
            r.op   = operation;
            r.req  = request_size;
            r.addr = address;
            p = predict_heap(r);
            if (r.op == OP_ALLOC && p.st == ST_OK)
            begin
                live_offsets.push_back(p.addr);
                ok_allocs++;
            end
            expected_rsps.push_back(p);
            beats_in++;
        end
    end

    // Receiver stall, redrawn per result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                recv_gap  <= $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            heap_rsp_t e;
            beats_out++;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result beat: status=%0d addr=%h", status, result_address);
                error_count++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    error_count++;
                end
                if (result_address !== e.addr)
                begin
                    $error("result_address: expected %h, got %h", e.addr, result_address);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd3_000_000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("first_fit_block_allocator_core_tb: done, errors");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (a == REG_INIT)
            sh_init_bytes = d;
        else
            sh_max_bytes = d;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_req(input logic [1:0] op, input logic [31:0] req,
                             input logic [31:0] addr);
        heap_req_t r;
        r.op   = op;
        r.req  = req;
        r.addr = addr;
        pending_reqs.push_back(r);
    endtask

    // Waits for every queued beat to be answered, then lets a full scan go by.
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (4 * MAX_BLOCKS + 20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 32'($urandom_range(0, 40));
            1: return $urandom();
            2: return 32'($urandom_range(0, 65535));
            default: return 32'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic random_phase(input int unsigned n);
        logic [31:0] a;
        int unsigned j;
        for (int unsigned k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    queue_req(OP_ALLOC, pick_size(), $urandom());
                9, 10, 11, 12, 13, 14, 15:
                begin
                    // Free a block handed out earlier; stale ones give double frees.
                    if (live_offsets.size() > 0)
                    begin
                        j = $urandom_range(0, live_offsets.size() - 1);
                        a = live_offsets[j];
                        if ($urandom_range(0, 3) != 0)
                            live_offsets.delete(j);
                    end
                    else
                        a = 32'($urandom_range(1, 4096)) * 32;
                    queue_req(OP_FREE, $urandom(), a);
                end
                16: queue_req(OP_FREE, $urandom(), $urandom());
                17: queue_req(OP_FREE, $urandom(), '0);
                18: queue_req(OP_UNUSED, $urandom(), $urandom());
                default:
                begin
                    queue_req(OP_INIT, $urandom(), $urandom());
                end
            endcase
            // Offsets seen by the driver come from the shadow as beats are accepted,
            // so hand out one beat at a time during random traffic.
            while (pending_reqs.size() > 0 || in_valid)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        operation    = OP_ALLOC;
        request_size = '0;
        address      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        error_count  = 0;
        beats_in     = 0;
        beats_out    = 0;
        ok_allocs    = 0;
        merges_seen  = 0;
        cycle_count  = 0;
        send_gap     = 0;
        recv_gap     = 0;
        in_taken     = 1'b0;
        out_taken    = 1'b0;
        sh_init_bytes = INIT_RESET;
        sh_max_bytes  = MAXH_RESET;
        heap_setup();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset heap, splits, merges, error codes, unused opcode.
        queue_req(OP_ALLOC, 32'd100, '0);
        queue_req(OP_ALLOC, 32'd0, '0);
        queue_req(OP_ALLOC, 32'd200, '0);
        queue_req(OP_FREE, '0, 32'd32);
        queue_req(OP_FREE, '0, 32'd32);
        queue_req(OP_FREE, '0, '0);
        queue_req(OP_FREE, '0, 32'd33);
        queue_req(OP_FREE, '0, 32'hFFFF_FFFF);
        queue_req(OP_FREE, '0, 32'd164);
        queue_req(OP_FREE, '0, 32'd196);
        queue_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_ALLOC, 32'hFFFF_FFFF, '0);
        queue_req(OP_ALLOC, 32'd2_000_000, '0);
        drain();

        // Small heap: whole-block allocation, growth up to the limit.
        apb_write(REG_INIT, 32'd64);
        apb_write(REG_MAXH, 32'd64);
        queue_req(OP_INIT, '0, '0);
        queue_req(OP_ALLOC, 32'd10, '0);
        queue_req(OP_ALLOC, 32'd10, '0);
        queue_req(OP_FREE, '0, 32'd32);
        drain();
        apb_write(REG_MAXH, 32'hFFFF_FFFF);
        apb_write(REG_INIT, 32'd8);
        queue_req(OP_INIT, '0, '0);
        queue_req(OP_ALLOC, 32'd0, '0);
        queue_req(OP_ALLOC, 32'd5, '0);
        queue_req(OP_ALLOC, 32'hFFFF_FFF0, '0);
        queue_req(OP_ALLOC, 32'd16, '0);
        drain();

        // Fill the table so the full-table paths are reached.
        apb_write(REG_INIT, 32'hFFFF_FFFF);
        queue_req(OP_INIT, '0, '0);
        for (int k = 0; k < 70; k++)
            queue_req(OP_ALLOC, 32'd64, '0);
        drain();
        apb_write(REG_INIT, 32'd64);
        queue_req(OP_INIT, '0, '0);
        for (int k = 0; k < 70; k++)
            queue_req(OP_ALLOC, 32'd100, '0);
        drain();

        // Random phases over several register settings.
        apb_write(REG_INIT, 32'd4096);
        apb_write(REG_MAXH, 32'd65536);
        queue_req(OP_INIT, '0, '0);
        random_phase(100);
        drain();
        apb_write(REG_INIT, 32'd1000);
        apb_write(REG_MAXH, 32'hFFFF_FFFF);
        queue_req(OP_INIT, '0, '0);
        random_phase(100);
        drain();
        apb_write(REG_INIT, INIT_RESET);
        apb_write(REG_MAXH, 32'd200);
        queue_req(OP_INIT, '0, '0);
        random_phase(100);
        drain();

        $display("covered %0d beats in, %0d results, %0d successful allocations, %0d merges",
                 beats_in, beats_out, ok_allocs, merges_seen);
        if (error_count == 0)
            $display("first_fit_block_allocator_core_tb: done, clean");
        else
            $display("first_fit_block_allocator_core_tb: done, errors");
        $finish;
    end

endmodule
